FILE: rtl/isort_pkg.sv
// Package for the insertion sorter: data widths, default depth and the
// control bundle that the top level broadcasts to every cell. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

  localparam int VAL_W     = 32;
  localparam int DEPTH_DEF = 64;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic ins;
    logic drain;
    val_t value;
  } isort_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/insertion_sorter.sv
// Top level of the insertion sorter: a chain of DEPTH sorting cells and the
// control that inserts beats and drains the sorted set. Uses isort_pkg, isort_cell.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted input beat is inserted into the chain of cells, so
// input beats are taken back to back while a set is being collected. The beat
// flagged last is inserted as well and then the chain drains through cell 0,
// one result beat per cycle without output stall, N beats for N stored
// entries; in_stall is high during that drain. Values beyond DEPTH entries are
// dropped and every result beat of that set carries overflow.
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire val_t in_value,
  input  wire logic in_last,
  output      logic out_valid,
  input  wire logic out_stall,
  output      val_t out_sorted_value,
  output      logic out_end_of_set,
  output      logic out_overflow
);

  logic       draining_r;
  logic       draining_nxt;
  logic       dropped_r;
  logic       dropped_nxt;
  logic       in_acc;
  logic       out_acc;
  logic       full;
  isort_ctl_t ctl;

  val_t cell_val   [DEPTH];
  logic cell_valid [DEPTH];
  logic cell_here  [DEPTH];

  assign in_stall = draining_r;
  assign in_acc   = in_valid && !draining_r;
  assign out_acc  = out_valid && !out_stall;
  assign full     = cell_valid[DEPTH-1];

  assign ctl.ins   = in_acc && !full;
  assign ctl.drain = out_acc;
  assign ctl.value = in_value;

  assign out_valid        = draining_r;
  assign out_sorted_value = cell_val[0];
  assign out_end_of_set   = !cell_valid[1];
  assign out_overflow     = dropped_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic l_here;
    val_t l_val;
    logic l_valid;
    val_t r_val;
    logic r_valid;

    if (i == 0) begin : g_first
      assign l_here  = 1'b0;
      assign l_val   = '0;
      assign l_valid = 1'b0;
    end else begin : g_mid
      assign l_here  = cell_here[i-1];
      assign l_val   = cell_val[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_val   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_val   = cell_val[i+1];
      assign r_valid = cell_valid[i+1];
    end

    isort_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_here   (l_here),
      .left_val    (l_val),
      .left_valid  (l_valid),
      .right_val   (r_val),
      .right_valid (r_valid),
      .here        (cell_here[i]),
      .val         (cell_val[i]),
      .valid       (cell_valid[i])
    );
  end

  always_comb begin
    draining_nxt = draining_r;
    dropped_nxt  = dropped_r;
    if (in_acc) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_last) begin
        draining_nxt = 1'b1;
      end
    end
    if (out_acc && out_end_of_set) begin
      draining_nxt = 1'b0;
      dropped_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      dropped_r  <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      dropped_r  <= dropped_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/isort_cell.sv
// One cell of the insertion chain: holds one sorted entry and its valid bit.
// Depends on isort_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isort_cell
  import isort_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire isort_ctl_t ctl,
  input  wire logic       left_here,
  input  wire val_t       left_val,
  input  wire logic       left_valid,
  input  wire val_t       right_val,
  input  wire logic       right_valid,
  output      logic       here,
  output      val_t       val,
  output      logic       valid
);

  val_t val_r;
  val_t val_nxt;
  logic valid_r;
  logic valid_nxt;

  // A cell is at or above the insertion point when it is empty or strictly
  // greater than the new value.
  assign here  = !valid_r || (val_r > ctl.value);
  assign val   = val_r;
  assign valid = valid_r;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.drain) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end else if (ctl.ins) begin
      if (left_here) begin
        val_nxt   = left_val;
        valid_nxt = left_valid;
      end else if (here) begin
        val_nxt   = ctl.value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire
